[src/fexp_pkg.sv]
// Shared constants, types and fp32 arithmetic functions for the exp block.
package fexp_pkg;

   localparam logic [31:0] K_MAGIC    = 32'h4B40007F;
   localparam logic [31:0] K_NMAGIC   = 32'hCB40007F;
   localparam logic [31:0] K_LOG2E    = 32'h3FB8AA3B;
   localparam logic [31:0] K_MLN2_HI  = 32'hBF317200;
   localparam logic [31:0] K_MLN2_LO  = 32'hB5BFBE8E;
   localparam logic [31:0] K_C5       = 32'h3C07CFCE;
   localparam logic [31:0] K_C4       = 32'h3D2B9D0D;
   localparam logic [31:0] K_C3       = 32'h3E2AAD40;
   localparam logic [31:0] K_C2       = 32'h3EFFFEE3;
   localparam logic [31:0] K_C1       = 32'h3F7FFFFB;
   localparam logic [31:0] K_CUTOFF   = 32'hC2AEAC4F;
   localparam logic [31:0] QNAN       = 32'h7FC00000;
   localparam logic [31:0] QUIET_BIT  = 32'h00400000;
   localparam int unsigned EXP_SHIFT  = 23;

   // Side information that travels with each item down the pipeline.
   typedef struct packed {
      logic        is_nan;
      logic        below;
      logic        last;
      logic [31:0] x;
   } side_type;

   function automatic logic is_nan(input logic [31:0] a);
      is_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
   endfunction

   // Round and pack a normalized value: sign, unbiased-ish exponent, 27-bit
   // significand with hidden bit at 26 and a sticky bit at 0.
   function automatic logic [31:0] fp_round(input logic s, input logic signed [10:0] e,
                                            input logic [26:0] m);
      logic [26:0] mm;
      logic signed [10:0] ee;
      logic [4:0] sh;
      logic        st;
      logic [24:0] r;
      logic        inc;
      mm = m;
      ee = e;
      // Denormalize below the smallest normal exponent.
      if (ee < 11'sd1) begin
         sh = (ee < -11'sd26) ? 5'd27 : 5'(11'sd1 - ee);
         st = 1'b0;
         for (int i = 0; i < 27; i++)
            if (i < int'(sh) && mm[i]) st = 1'b1;
         mm = (sh >= 5'd27) ? 27'd0 : (mm >> sh);
         mm[0] = mm[0] | st;
         ee = 11'sd0;
      end
      inc = mm[2] & (mm[1] | mm[0] | mm[3]);
      r = {1'b0, mm[26:3]} + 25'(inc);
      if (r[24]) begin
         r = r >> 1;
         ee = ee + 11'sd1;
      end else if (ee == 11'sd0 && r[23]) begin
         ee = 11'sd1;
      end
      if (ee >= 11'sd255) fp_round = {s, 8'hFF, 23'd0};
      else fp_round = {s, ee[7:0], r[22:0]};
   endfunction

   function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
      logic        s;
      logic [23:0] ma, mb;
      logic signed [10:0] ea, eb, e;
      logic [47:0] p;
      logic [26:0] m;
      logic [5:0]  lz;
      logic        found;
      s  = a[31] ^ b[31];
      ma = {(a[30:23] != 8'd0), a[22:0]};
      mb = {(b[30:23] != 8'd0), b[22:0]};
      ea = (a[30:23] == 8'd0) ? 11'sd1 : 11'(a[30:23]);
      eb = (b[30:23] == 8'd0) ? 11'sd1 : 11'(b[30:23]);
      p  = ma * mb;
      lz = 6'd0;
      found = 1'b0;
      for (int i = 47; i >= 0; i--)
         if (!found && p[i]) begin
            found = 1'b1;
            lz = 6'(47 - i);
         end
      if (is_nan(a) || is_nan(b)) fp_mul = QNAN;
      else if ((a[30:23] == 8'hFF && b[30:0] == 31'd0) ||
               (b[30:23] == 8'hFF && a[30:0] == 31'd0)) fp_mul = QNAN;
      else if (a[30:23] == 8'hFF || b[30:23] == 8'hFF) fp_mul = {s, 8'hFF, 23'd0};
      else if (!found) fp_mul = {s, 31'd0};
      else begin
         p = p << lz;
         m = {p[47:22], (p[21:0] != 22'd0)};
         e = ea + eb - 11'sd126 - 11'(lz);
         fp_mul = fp_round(s, e, m);
      end
   endfunction

   function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] x, y;
      logic [7:0]  ex, ey, d;
      logic [50:0] mx, my, sum;
      logic        sub, found;
      logic [5:0]  lz;
      logic signed [10:0] e;
      logic [26:0] m;
      if ({1'b0, a[30:0]} >= {1'b0, b[30:0]}) begin x = a; y = b; end
      else begin x = b; y = a; end
      ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
      ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
      d  = ex - ey;
      mx = {1'b0, (x[30:23] != 8'd0), x[22:0], 26'd0};
      my = {1'b0, (y[30:23] != 8'd0), y[22:0], 26'd0};
      if (d > 8'd49) my = {50'd0, (my != 51'd0)};
      else my = (my >> d) | 51'(((my & ((51'd1 << d) - 51'd1)) != 51'd0));
      sub = x[31] ^ y[31];
      sum = sub ? (mx - my) : (mx + my);
      lz = 6'd0;
      found = 1'b0;
      for (int i = 50; i >= 0; i--)
         if (!found && sum[i]) begin
            found = 1'b1;
            lz = 6'(50 - i);
         end
      if (is_nan(a) || is_nan(b)) fp_add = QNAN;
      else if (a[30:23] == 8'hFF && b[30:23] == 8'hFF && sub) fp_add = QNAN;
      else if (x[30:23] == 8'hFF) fp_add = x;
      else if (!found) fp_add = (a[31] & b[31]) ? 32'h80000000 : 32'd0;
      else begin
         sum = sum << lz;
         m = {sum[50:25], (sum[24:0] != 25'd0)};
         e = 11'(ex) + 11'sd1 - 11'(lz);
         fp_add = fp_round(x[31], e, m);
      end
   endfunction

   // Signed compare a < b for non-NaN fp32 values.
   function automatic logic fp_lt(input logic [31:0] a, input logic [31:0] b);
      if (a[31] != b[31]) fp_lt = a[31] && ((a[30:0] | b[30:0]) != 31'd0);
      else if (a[31]) fp_lt = a[30:0] > b[30:0];
      else fp_lt = a[30:0] < b[30:0];
   endfunction

endpackage

[src/fexp_stage.sv]
// One pipeline stage: one fp32 multiply or add with a registered result.
module fexp_stage
   import fexp_pkg::*;
#(
   parameter bit IS_MUL = 1'b1
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        enable,
   input  logic        valid_in,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic        valid_out,
   output logic [31:0] q
);

   logic [31:0] q_ff, q_in;
   logic        v_ff;

   // Single rounded operation.
   assign q_in = IS_MUL ? fp_mul(a, b) : fp_add(a, b);

   always_ff @(posedge clock) begin
      if (reset) v_ff <= 1'b0;
      else if (enable) v_ff <= valid_in;
      if (enable) q_ff <= q_in;
   end

   assign valid_out = v_ff;
   assign q = q_ff;

endmodule

[src/fp32_exp_negative_range.sv]
// Top level of the pipelined fp32 exp(x) unit for non-positive inputs.
// Usage:
//   The req_ channel carries one fp32 value x per beat in req_tdata and the
//   end-of-vector flag in req_tlast. The rsp_ channel returns the fp32 bits
//   of exp(x) in rsp_tdata and the same flag in rsp_tlast.
//   Inputs below about -87.3 give +0.0; NaN inputs return quieted.
// Pipeline and throughput:
//   Every item walks through 18 register stages, one rounded fp32 multiply
//   or add each.
//   One beat is accepted every cycle while the pipeline is not held.
// Reset:
//   A synchronous, active-high reset clears all valid bits; no result is
//   pending afterwards.
// Stall:
//   When rsp_tready is low while the last stage holds a result, the whole
//   pipeline holds; req_tready drops only while the last stage holds a
//   result and the receiver is stalled, so no beat is lost or repeated.
module fp32_exp_negative_range
   import fexp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // x_bits[31:0]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // result_bits[31:0]
   output logic        rsp_tlast
);

   localparam int NST = 16;

   logic        en;
   logic [NST:0] v;
   logic [31:0] r [NST+1];
   side_type    sd_ff [NST+1];
   side_type    side_in;
   // Values kept for later stages.
   logic [31:0] nb_ff [NST+1];
   logic [31:0] s_ff [NST+1];
   logic [31:0] t_ff [NST+1];
   logic [31:0] p_ff [NST+1];
   logic [31:0] sa [NST];
   logic [31:0] sb [NST];
   logic [31:0] res;
   // Tail stages after the arithmetic chain.
   logic [31:0] tp_ff, s2_ff;
   logic        v2_ff, v3_ff;
   side_type    sd2_ff, sd3_ff;
   logic [31:0] f_ff;

   assign en = !v3_ff || rsp_tready;
   assign req_tready = en;
   assign v[0] = req_tvalid;
   assign r[0] = 32'd0;

   // Classify input once at entry.
   always_comb begin
      side_in.x      = req_tdata;
      side_in.last   = req_tlast;
      side_in.is_nan = is_nan(req_tdata);
      side_in.below  = fp_lt(req_tdata, K_CUTOFF);
   end
   assign sd_ff[0] = side_in;
   assign nb_ff[0] = 32'd0;
   assign s_ff[0]  = 32'd0;
   assign t_ff[0]  = 32'd0;
   assign p_ff[0]  = 32'd0;

   // Operands of each stage, following the Horner schedule.
   always_comb begin
      sa[0]  = sd_ff[0].x;       sb[0]  = K_LOG2E;
      sa[1]  = r[1];             sb[1]  = K_MAGIC;
      sa[2]  = r[2];             sb[2]  = K_NMAGIC;
      sa[3]  = r[3];             sb[3]  = K_MLN2_HI;
      sa[4]  = r[4];             sb[4]  = sd_ff[4].x;
      sa[5]  = nb_ff[5];         sb[5]  = K_MLN2_LO;
      sa[6]  = r[6];             sb[6]  = nb_ff[6];
      sa[7]  = K_C5;             sb[7]  = r[7];
      sa[8]  = r[8];             sb[8]  = K_C4;
      sa[9]  = r[9];             sb[9]  = t_ff[9];
      sa[10] = r[10];            sb[10] = K_C3;
      sa[11] = r[11];            sb[11] = t_ff[11];
      sa[12] = r[12];            sb[12] = K_C2;
      sa[13] = r[13];            sb[13] = t_ff[13];
      sa[14] = r[14];            sb[14] = K_C1;
      sa[15] = t_ff[15];         sb[15] = s_ff[15];
   end

   // Arithmetic stages; the last multiply-add pair is folded below.
   for (genvar i = 0; i < NST; i++) begin : g_st
      localparam bit MUL = (i == 0 || i == 3 || i == 5 || i == 7 || i == 9 ||
                            i == 11 || i == 13 || i == 15);
      fexp_stage #(.IS_MUL(MUL)) u_st (
         .clock(clock), .reset(reset), .enable(en), .valid_in(v[i]),
         .a(sa[i]), .b(sb[i]), .valid_out(v[i+1]), .q(r[i+1]));

      // Side registers alongside each stage. The n register is reused for
      // the first reduced value once n has been consumed.
      always_ff @(posedge clock) begin
         if (en) begin
            sd_ff[i+1] <= sd_ff[i];
            nb_ff[i+1] <= (i == 3) ? r[3] : ((i == 5) ? r[5] : nb_ff[i]);
            s_ff[i+1]  <= (i == 2) ? (r[2] << EXP_SHIFT) : s_ff[i];
            t_ff[i+1]  <= (i == 7) ? r[7] : t_ff[i];
            p_ff[i+1]  <= (i == 15) ? r[15] : p_ff[i];
         end
      end
   end

   // Tail stages: (t*s)*p in one register stage, then plus s in the next.
   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v[NST];
         v3_ff <= v2_ff;
      end
      if (en) begin
         tp_ff  <= fp_mul(r[NST], p_ff[NST]);
         s2_ff  <= s_ff[NST];
         sd2_ff <= sd_ff[NST];
         f_ff   <= fp_add(tp_ff, s2_ff);
         sd3_ff <= sd2_ff;
      end
   end

   always_comb begin
      if (sd3_ff.is_nan) res = sd3_ff.x | QUIET_BIT;
      else if (sd3_ff.below) res = 32'd0;
      else if (is_nan(f_ff)) res = QNAN;
      else res = f_ff;
   end

   assign rsp_tvalid = v3_ff;
   assign rsp_tdata  = res;
   assign rsp_tlast  = sd3_ff.last;

endmodule

[sim/tb_fp32_exp_negative_range.sv]
// Self-checking testbench for the pipelined fp32 exp(x) unit.
`timescale 1ns / 100ps

module tb_fp32_exp_negative_range;
   import fexp_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // x_bits[31:0]
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // result_bits[31:0]
   logic        rsp_tlast;

   typedef struct {
      logic [31:0] x;
      logic        last;
      int unsigned gap;
      bit          drain;
   } beat_t;

   typedef struct {
      logic [31:0] bits;
      logic        last;
   } exp_result_t;

   beat_t       pending_beats[$];
   exp_result_t expected_exp[$];
   int unsigned mismatches;
   int unsigned results_seen;
   bit          sender_idle;

   fp32_exp_negative_range u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

   // Widen fp32 bits to a double; every fp32 value is exact in double.
   function automatic real sp_to_real(input logic [31:0] a);
      logic [63:0] d;
      if (a[30:23] == 8'hFF) begin
         d = {a[31], 11'h7FF, a[22:0], 29'd0};
         return $bitstoreal(d);
      end
      if (a[30:23] == 8'd0) begin
         if (a[31]) return -(real'(a[22:0]) * 2.0 ** (-149));
         return real'(a[22:0]) * 2.0 ** (-149);
      end
      d = {a[31], 11'(int'(a[30:23]) - 127 + 1023), a[22:0], 29'd0};
      return $bitstoreal(d);
   endfunction

   // Round a double to fp32, nearest even, keeping subnormals.
   // Double rounding is harmless here since 53 >= 2*24 + 2.
   function automatic logic [31:0] real_to_sp(input real r);
      logic [63:0] d;
      logic        sgn;
      int          e2;
      int          sh;
      logic [63:0] m;
      logic [63:0] q;
      logic        guard;
      logic        sticky;
      longint      packed_val;
      d   = $realtobits(r);
      sgn = d[63];
      if (d[62:52] == 11'h7FF) begin
         if (d[51:0] != 52'd0) return QNAN;
         return {sgn, 8'hFF, 23'd0};
      end
      if (d[62:0] == 63'd0) return {sgn, 31'd0};
      // Products and sums of fp32 values never land in the double subnormal range.
      e2 = int'(d[62:52]) - 1023;
      m  = {11'd0, 1'b1, d[51:0]};
      sh = (e2 >= -126) ? 29 : 29 + (-126 - e2);
      if (sh > 60) sh = 60;
      q      = m >> sh;
      guard  = m[sh - 1];
      sticky = (m & ((64'd1 << (sh - 1)) - 64'd1)) != 64'd0;
      q      = q + 64'(guard & (sticky | q[0]));
      if (e2 < -126) return {sgn, 31'(q)};
      packed_val = (longint'(e2 + 127) << 23) + longint'(q) - (64'sd1 << 23);
      if (packed_val >= 64'sh7F800000) return {sgn, 8'hFF, 23'd0};
      return {sgn, 31'(packed_val)};
   endfunction

   function automatic logic [31:0] sp_mul(input logic [31:0] a, input logic [31:0] b);
      return real_to_sp(sp_to_real(a) * sp_to_real(b));
   endfunction

   function automatic logic [31:0] sp_add(input logic [31:0] a, input logic [31:0] b);
      return real_to_sp(sp_to_real(a) + sp_to_real(b));
   endfunction

   function automatic bit sp_is_nan(input logic [31:0] a);
      return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
   endfunction

   // exp(x) by magic-bias rounding, Cody-Waite reduction and a degree-5 Horner step.
   function automatic logic [31:0] predict_exp(input logic [31:0] x);
      logic [31:0] n, scale, t, p, f;
      if (sp_is_nan(x)) return x | QUIET_BIT;
      n     = sp_add(sp_mul(x, K_LOG2E), K_MAGIC);
      scale = n << EXP_SHIFT;
      n     = sp_add(n, K_NMAGIC);
      t     = sp_add(sp_mul(n, K_MLN2_HI), x);
      t     = sp_add(sp_mul(n, K_MLN2_LO), t);
      p     = sp_add(sp_mul(K_C5, t), K_C4);
      p     = sp_add(sp_mul(p, t), K_C3);
      p     = sp_add(sp_mul(p, t), K_C2);
      p     = sp_add(sp_mul(p, t), K_C1);
      t     = sp_mul(t, scale);
      f     = sp_add(sp_mul(t, p), scale);
      if (sp_to_real(x) < sp_to_real(K_CUTOFF)) return 32'd0;
      if (sp_is_nan(f)) return QNAN;
      return f;
   endfunction

   // Clock.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Driver: presents queued beats after their gap and logs the expectation
   // of every beat the block takes.
   beat_t       cur_beat;
   bit          beat_loaded;
   int unsigned wait_left;

   always @(posedge clock) begin
      logic next_valid;
      exp_result_t want;
      if (reset) begin
         req_tvalid  <= 1'b0;
         beat_loaded = 1'b0;
         wait_left   = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            want.bits = predict_exp(req_tdata);
            want.last = req_tlast;
            expected_exp.push_back(want);
         end
         if (!req_tvalid || req_tready) begin
            next_valid = 1'b0;
            if (!beat_loaded && pending_beats.size() != 0) begin
               cur_beat    = pending_beats.pop_front();
               beat_loaded = 1'b1;
               wait_left   = cur_beat.gap;
            end
            if (beat_loaded) begin
               if (wait_left > 0) begin
                  wait_left--;
               end else if (!(cur_beat.drain && expected_exp.size() != 0)) begin
                  req_tdata   <= cur_beat.x;
                  req_tlast   <= cur_beat.last;
                  next_valid  = 1'b1;
                  beat_loaded = 1'b0;
               end
            end
            req_tvalid <= next_valid;
         end
      end
      sender_idle = !beat_loaded && pending_beats.size() == 0;
   end

   // Monitor: stalls the result side at random and checks each result beat.
   int unsigned stall_left;

   always @(posedge clock) begin
      exp_result_t want;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (expected_exp.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Unexpected result beat: data %h last %b", rsp_tdata, rsp_tlast);
            end else begin
               want = expected_exp.pop_front();
               if (rsp_tdata !== want.bits || rsp_tlast !== want.last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("Mismatch: expected data %h last %b, got data %h last %b",
                              want.bits, want.last, rsp_tdata, rsp_tlast);
               end
            end
            // Every fourth stretch of 64 results runs without stalls.
            stall_left = ((results_seen / 64) % 4 == 1) ? 0 : $urandom_range(0, 13);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic queue_beat(input logic [31:0] x, input logic last, input int unsigned gap,
                             input bit drain);
      beat_t b;
      b.x     = x;
      b.last  = last;
      b.gap   = gap;
      b.drain = drain;
      pending_beats.push_back(b);
   endtask

   // Mostly in-range negative values, some anything at all.
   function automatic logic [31:0] random_x();
      logic [31:0] v;
      v = $urandom;
      if ($urandom_range(0, 9) < 7) begin
         v[31]    = 1'b1;
         v[30:23] = 8'($urandom_range(90, 133));
      end
      return v;
   endfunction

   // Stimulus and end of run.
   initial begin
      logic [31:0] corner[$];
      int unsigned gap;
      mismatches   = 0;
      results_seen = 0;
      sender_idle  = 1'b0;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = 32'd0;
      req_tlast    = 1'b0;
      rsp_tready   = 1'b0;

      // Zeros, the cutoff and its neighbors, infinities, NaNs, subnormals, extremes.
      corner = '{32'h00000000, 32'h80000000, 32'hBF800000, K_CUTOFF, 32'hC2AEAC50,
                 32'hC2AEAC4E, 32'hFF800000, 32'h7F800000, QNAN, 32'h7F800001,
                 32'hFFC00001, 32'hFFBFFFFF, 32'h00000001, 32'h80000001, 32'h807FFFFF,
                 32'h7F7FFFFF, 32'hFF7FFFFF, 32'h3F800000, 32'h42B00000, 32'hC2AE0000,
                 32'hBF000000, 32'hB2000000, 32'hBF317218, 32'hC1280000, 32'hFFFFFFFF};
      foreach (corner[i]) queue_beat(corner[i], i[0], $urandom_range(0, 2), 1'b0);

      for (int i = 0; i < 650; i++) begin
         gap = ((i / 80) % 3 == 1) ? 0 : $urandom_range(0, 13);
         queue_beat(random_x(), ($urandom_range(0, 7) == 0), gap, (i % 200 == 100));
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Wait for the sender and the pipeline to empty, then for stray beats.
      @(posedge clock);
      while (!(sender_idle && !req_tvalid && expected_exp.size() == 0))
         @(posedge clock);
      repeat (40) @(posedge clock);

      if (mismatches == 0 && expected_exp.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   // Watchdog.
   initial begin
      #5_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
